// File: rtl/core/dfmt_pkg.sv
// Package for the decimal integer formatter: constants, length-mode codes,
// ASCII codes. No dependencies.
package dfmt_pkg;

    localparam int MAX_FIELD_DEF  = 64;
    localparam int MAX_DIGITS_DEF = 20;
    localparam int PREC_LIMIT     = 40;
    localparam int VALUE_W        = 64;

    localparam logic [1:0] LM_32   = 2'd0;
    localparam logic [1:0] LM_16   = 2'd1;
    localparam logic [1:0] LM_64   = 2'd2;
    localparam logic [1:0] LM_RSVD = 2'd3;   // read as full 64 bits

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_ZERO  = 7'h30;

endpackage

// File: rtl/core/dfmt_if.sv
// Valid/ready channels of the decimal integer formatter.
// Depends on nothing.
interface dfmt_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        is_unsigned;
    logic [1:0]  length_mode;
    logic        flag_left_align;
    logic        flag_plus;
    logic        flag_space;
    logic [6:0]  field_width;
    logic        precision_given;
    logic [5:0]  precision;
    modport source (output valid, value, is_unsigned, length_mode, flag_left_align,
                    flag_plus, flag_space, field_width, precision_given, precision,
                    input ready);
    modport sink (input valid, value, is_unsigned, length_mode, flag_left_align,
                  flag_plus, flag_space, field_width, precision_given, precision,
                  output ready);
endinterface

interface dfmt_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       is_last;
    logic       is_empty;
    modport source (output valid, out_char, is_last, is_empty, input ready);
    modport sink (input valid, out_char, is_last, is_empty, output ready);
endinterface

// File: rtl/core/decimal_integer_formatter.sv
// Top level of the decimal integer formatter (printf %d/%i/%u field).
// Depends on dfmt_pkg, dfmt_if (dfmt_in_if, dfmt_out_if) and dfmt_cell.
//
//  channel  dir  payload
//  i_in     in   value, is_unsigned, length_mode, flags, field_width, precision
//  o_out    out  out_char, is_last, is_empty
//
// Sequence: accept, 64 conversion steps (one bit into the cell row per
// cycle), setup, then one character per cycle unless o_out.ready stalls;
// an empty field still gives one word.
// Reset: synchronous, active low; clears the sequencer and output valid.
// Stalls: o_out.ready low freezes character emission; i_in.ready is high
// only between items, and may rise while the last word still waits.
module decimal_integer_formatter #(
    parameter int MAX_FIELD  = dfmt_pkg::MAX_FIELD_DEF,
    parameter int MAX_DIGITS = dfmt_pkg::MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dfmt_in_if.sink     i_in,
    dfmt_out_if.source  o_out
);
    localparam int NDW = $clog2(MAX_DIGITS + 1);
    localparam int DIW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [6:0] FIELD_CAP = (MAX_FIELD > 127) ? 7'd127 : 7'(MAX_FIELD);
    localparam logic [5:0] PREC_CAP  = 6'(dfmt_pkg::PREC_LIMIT);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_SETUP = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // item settings
    logic [63:0] r_mag;
    logic        r_zero;
    logic        r_sgn;
    logic [6:0]  r_sign_ch;
    logic [6:0]  r_w;
    logic [5:0]  r_prec;
    logic        r_pg;
    logic        r_left;
    logic [5:0]  r_cnt;
    logic        r_ovf;

    // emission counters
    logic [6:0]     r_lpad, r_rpad, r_rem;
    logic [5:0]     r_zeros;
    logic [NDW-1:0] r_ndig;

    // output register
    logic       r_oval;
    logic [6:0] r_ochar;
    logic       r_olast, r_oempty;

    // cell row
    logic [3:0] w_dig [MAX_DIGITS];
    logic       w_carry [MAX_DIGITS];
    logic       w_clr, w_shift;
    logic       w_acc;

    assign w_acc   = i_in.valid && i_in.ready;
    assign w_clr   = w_acc;
    assign w_shift = (r_state == S_CONV);

    genvar g;
    generate
        for (g = 0; g < MAX_DIGITS; g++) begin : g_cell
            if (g == 0) begin : g_first
                dfmt_cell u_cell (
                    .i_clk  (i_clk),
                    .i_clr  (w_clr),
                    .i_shift(w_shift),
                    .i_bit  (r_mag[63]),
                    .o_digit(w_dig[g]),
                    .o_carry(w_carry[g])
                );
            end else begin : g_next
                dfmt_cell u_cell (
                    .i_clk  (i_clk),
                    .i_clr  (w_clr),
                    .i_shift(w_shift),
                    .i_bit  (w_carry[g-1]),
                    .o_digit(w_dig[g]),
                    .o_carry(w_carry[g])
                );
            end
        end
    endgenerate

    // input decode: truncate, sign, magnitude, width and precision clamps
    logic [63:0] w_mask, w_x, w_mag;
    logic        w_neg, w_top;
    logic [6:0]  w_w;
    logic [5:0]  w_p;

    always_comb begin
        unique case (i_in.length_mode)
            dfmt_pkg::LM_32: begin
                w_mask = 64'h0000_0000_FFFF_FFFF;
                w_top  = i_in.value[31];
            end
            dfmt_pkg::LM_16: begin
                w_mask = 64'h0000_0000_0000_FFFF;
                w_top  = i_in.value[15];
            end
            default: begin
                w_mask = {64{1'b1}};
                w_top  = i_in.value[63];
            end
        endcase
        w_x   = i_in.value & w_mask;
        w_neg = !i_in.is_unsigned && w_top;
        w_mag = w_neg ? ((~w_x + 64'd1) & w_mask) : w_x;
        w_w   = (i_in.field_width > FIELD_CAP) ? FIELD_CAP : i_in.field_width;
        if (!i_in.precision_given) begin
            w_p = 6'd0;
        end else begin
            w_p = (i_in.precision > PREC_CAP) ? PREC_CAP : i_in.precision;
        end
    end

    // setup: digit count, zeros, padding
    logic [NDW-1:0] w_ndig;
    logic [5:0]     w_zeros;
    logic [6:0]     w_body, w_pad;

    always_comb begin
        w_ndig = '0;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (w_dig[k] != 4'd0) w_ndig = NDW'(k + 1);
        end
        if (r_ovf) w_ndig = NDW'(MAX_DIGITS);
        if (w_ndig == '0) w_ndig = NDW'(1);
        if (r_pg && r_prec == 6'd0 && r_zero) w_ndig = '0;
        w_zeros = (r_prec > 6'(w_ndig)) ? r_prec - 6'(w_ndig) : 6'd0;
        w_body  = 7'(r_sgn) + 7'(w_zeros) + 7'(w_ndig);
        w_pad   = (r_w > w_body) ? r_w - w_body : 7'd0;
    end

    // emission
    logic           w_slot;
    logic [DIW-1:0] w_didx;
    assign w_slot = !r_oval || o_out.ready;
    assign w_didx = DIW'(r_ndig - NDW'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_acc) n_state = S_CONV;
            S_CONV:  if (r_cnt == 6'd63) n_state = S_SETUP;
            S_SETUP: n_state = S_EMIT;
            S_EMIT:  if (w_slot && r_rem <= 7'd1) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && w_slot) begin
                r_oval <= 1'b1;
            end else if (o_out.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mag     <= w_mag;
            r_zero    <= (w_mag == 64'd0);
            r_sgn     <= w_neg || (!i_in.is_unsigned && (i_in.flag_plus || i_in.flag_space));
            r_sign_ch <= w_neg ? dfmt_pkg::CH_MINUS :
                         i_in.flag_plus ? dfmt_pkg::CH_PLUS : dfmt_pkg::CH_SPACE;
            r_w       <= w_w;
            r_prec    <= w_p;
            r_pg      <= i_in.precision_given;
            r_left    <= i_in.flag_left_align;
            r_cnt     <= 6'd0;
            r_ovf     <= 1'b0;
        end else if (r_state == S_CONV) begin
            r_mag <= {r_mag[62:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
            r_ovf <= r_ovf | w_carry[MAX_DIGITS-1];
        end
        if (r_state == S_SETUP) begin
            r_ndig  <= w_ndig;
            r_zeros <= w_zeros;
            r_lpad  <= r_left ? 7'd0 : w_pad;
            r_rpad  <= r_left ? w_pad : 7'd0;
            r_rem   <= w_body + w_pad;
        end else if (r_state == S_EMIT && w_slot) begin
            r_olast  <= (r_rem <= 7'd1);
            r_oempty <= (r_rem == 7'd0);
            if (r_rem != 7'd0) r_rem <= r_rem - 7'd1;
            priority if (r_rem == 7'd0) begin
                r_ochar <= 7'd0;
            end else if (r_lpad != 7'd0) begin
                r_ochar <= dfmt_pkg::CH_SPACE;
                r_lpad  <= r_lpad - 7'd1;
            end else if (r_sgn) begin
                r_ochar <= r_sign_ch;
                r_sgn   <= 1'b0;
            end else if (r_zeros != 6'd0) begin
                r_ochar <= dfmt_pkg::CH_ZERO;
                r_zeros <= r_zeros - 6'd1;
            end else if (r_ndig != '0) begin
                r_ochar <= dfmt_pkg::CH_ZERO + {3'b000, w_dig[w_didx]};
                r_ndig  <= r_ndig - NDW'(1);
            end else begin
                r_ochar <= dfmt_pkg::CH_SPACE;
                r_rpad  <= r_rpad - 7'd1;
            end
        end
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_oval;
    assign o_out.out_char = r_ochar;
    assign o_out.is_last  = r_olast;
    assign o_out.is_empty = r_oempty;

endmodule

// File: rtl/core/dfmt_cell.sv
// One BCD digit cell of the binary-to-decimal chain (shift-and-add-3).
// No dependencies.
module dfmt_cell (
    input  logic       i_clk,
    input  logic       i_clr,
    input  logic       i_shift,
    input  logic       i_bit,
    output logic [3:0] o_digit,
    output logic       o_carry
);
    logic [3:0] r_d;
    logic [3:0] w_adj;

    // add 3 if digit >= 5, so the shift carries correctly into the next cell
    assign w_adj   = (r_d >= 4'd5) ? r_d + 4'd3 : r_d;
    assign o_carry = w_adj[3];
    assign o_digit = r_d;

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_d <= 4'd0;
        end else if (i_shift) begin
            r_d <= {w_adj[2:0], i_bit};
        end
    end
endmodule

// File: rtl/core/dfmt_checker.sv
// Port-level checks for the decimal integer formatter, bound to the top.
// Depends on decimal_integer_formatter.
module dfmt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_out_last,
    input logic       i_out_empty
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_last) && $stable(i_out_empty))
        else $error("stalled word changed");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_empty |-> i_out_last)
        else $error("empty word not last");

    a_no_take_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input taken mid field");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready after accept");
endmodule

bind decimal_integer_formatter dfmt_checker u_dfmt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_char (o_out.out_char),
    .i_out_last (o_out.is_last),
    .i_out_empty(o_out.is_empty)
);
